// File: hdl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and the byte-wide CRC-32 step for the packet
// seal-and-check block.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned PosW          = 6;
  localparam int unsigned DefPacketBytes = 48;
  localparam int unsigned TrailerBytes  = 4;

  localparam logic [7:0]  MarkFirst  = 8'hFE;
  localparam logic [7:0]  MarkSecond = 8'hCA;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_SEAL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_MARKER = 2'd1,
    STAT_BAD_CRC    = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e       command;
    logic       start_req;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
  } result_t;

  // Reflected CRC-32 over one byte: an XOR network after synthesis.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/psc_in_reg.sv
// ----------------------------------------------------------------------------
// psc_in_reg
// Input register: captures one transfer and holds it until the engine
// advances it into the result register.
// ----------------------------------------------------------------------------
module psc_in_reg import psc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/psc_engine.sv
// ----------------------------------------------------------------------------
// psc_engine
// Packet state (position, running CRC, marker and mismatch flags) and the
// per-byte seal/check logic. State moves only when an item advances.
// ----------------------------------------------------------------------------
module psc_engine import psc_pkg::*; #(
  parameter int unsigned PacketBytes = DefPacketBytes
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam logic [PosW-1:0] BodyPos = PosW'(PacketBytes - TrailerBytes);
  localparam logic [PosW-1:0] LastPos = PosW'(PacketBytes - 1);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [31:0]     crc_q, crc_d, crc_eff, crc_fin;
  logic            marker_q, marker_d, marker_eff;
  logic            mismatch_q, mismatch_d, mismatch_eff;
  logic [PosW-1:0] trail_off;
  logic [1:0]      trail_idx;
  logic [7:0]      expect_byte;
  logic            is_last, in_body, seal;

  // A start flag clears the packet state before the byte is taken.
  assign pos_eff      = item_i.start_req ? '0      : pos_q;
  assign crc_eff      = item_i.start_req ? CrcInit : crc_q;
  assign marker_eff   = item_i.start_req ? 1'b1    : marker_q;
  assign mismatch_eff = item_i.start_req ? 1'b0    : mismatch_q;

  assign seal        = (item_i.command == CMD_SEAL);
  assign in_body     = (pos_eff < BodyPos);
  assign is_last     = (pos_eff >= LastPos);
  assign crc_fin     = crc_eff ^ CrcInit;
  assign trail_off   = pos_eff - BodyPos;
  assign trail_idx   = trail_off[1:0];
  assign expect_byte = crc_fin[{trail_idx, 3'b000} +: 8];

  always_comb begin
    logic marker_n, mismatch_n;
    marker_n   = marker_eff;
    mismatch_n = mismatch_eff;
    crc_d      = crc_eff;
    result_o.out_byte = item_i.data_byte;
    result_o.last     = is_last;
    result_o.status   = STAT_OK;

    if (pos_eff == PosW'(0) && item_i.data_byte != MarkFirst) begin
      marker_n = 1'b0;
    end
    if (pos_eff == PosW'(1) && item_i.data_byte != MarkSecond) begin
      marker_n = 1'b0;
    end

    if (in_body) begin
      crc_d = crc32_byte(crc_eff, item_i.data_byte);
    end else if (seal) begin
      result_o.out_byte = expect_byte;
    end else if (item_i.data_byte != expect_byte) begin
      mismatch_n = 1'b1;
    end

    if (is_last && !seal) begin
      if (!marker_n) begin
        result_o.status = STAT_BAD_MARKER;
      end else if (mismatch_n) begin
        result_o.status = STAT_BAD_CRC;
      end
    end

    // Drop back to the idle packet state after the last byte.
    if (is_last) begin
      pos_d      = '0;
      crc_d      = CrcInit;
      marker_d   = 1'b1;
      mismatch_d = 1'b0;
    end else begin
      pos_d      = pos_eff + PosW'(1);
      marker_d   = marker_n;
      mismatch_d = mismatch_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      crc_q      <= CrcInit;
      marker_q   <= 1'b1;
      mismatch_q <= 1'b0;
    end else if (advance_i) begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      marker_q   <= marker_d;
      mismatch_q <= mismatch_d;
    end
  end

endmodule

// File: hdl/psc_out_reg.sv
// ----------------------------------------------------------------------------
// psc_out_reg
// Result register: holds a finished result until the downstream side takes
// the transfer.
// ----------------------------------------------------------------------------
module psc_out_reg import psc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = can_load_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// File: hdl/packet_seal_and_check_crc32_top.sv
// ----------------------------------------------------------------------------
// packet_seal_and_check_crc32_top
// Byte-stream packet sealer/checker with reflected CRC-32 trailer.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-----------------------------------
//   in      | in_valid_i/in_ready_o  | command_i, start_req_i, data_byte_i
//   out     | out_valid_o/out_ready_i| out_byte_o, last_o, status_o
//
// One byte per cycle sustained while the output is not stalled; a byte passes
// from the input register through the CRC step into the result register
// before it shows on the output and can leave.
// Reset clears both register valids and returns the packet state to idle.
// A stalled output holds its result; the input register still takes one
// more byte, after which in_ready_o drops until the output drains.
// ----------------------------------------------------------------------------
module packet_seal_and_check_crc32_top import psc_pkg::*; #(
  parameter int unsigned PacketBytes = DefPacketBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic       start_req_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  item_t   in_item, stage_item;
  result_t eng_result, out_result;
  logic    stage_valid, out_can_load, advance;

  assign in_item.command   = cmd_e'(command_i);
  assign in_item.start_req = start_req_i;
  assign in_item.data_byte = data_byte_i;

  assign advance = stage_valid && out_can_load;

  psc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  psc_engine #(
    .PacketBytes (PacketBytes)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .result_o  (eng_result)
  );

  psc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid),
    .result_i    (eng_result),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign out_byte_o = out_result.out_byte;
  assign last_o     = out_result.last;
  assign status_o   = out_result.status;

  // A non-ok status only ever comes with the final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> last_o)
    else $error("status reported on a non-final byte");

  // Input backpressure only when both registers are full and output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // A held input item must move on as soon as the output register frees up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && !out_valid_o) |-> advance)
    else $error("input item not advanced into empty result register");

endmodule
